/* hdl/swmf_pkg.sv */
// Shared types and constants for the sliding window median filter.
`default_nettype none

package swmf_pkg;

  localparam int PIX_BITS      = 16;
  localparam int WSIZE_BITS    = 3;
  localparam int WIDTH_BITS    = 11;
  localparam int HEIGHT_BITS   = 13;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 13;
  localparam int MAX_HEIGHT    = 4096;

  typedef logic [PIX_BITS-1:0] pixel_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WINDOW_SIZE  = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e opcode;
    pixel_t  pixel_value;
  } in_beat_t;

  typedef struct packed {
    pixel_t median_value;
    logic   row_last;
    logic   frame_last;
  } out_beat_t;

  typedef struct packed {
    logic row_last;
    logic frame_last;
  } tag_t;

endpackage

`default_nettype wire

/* hdl/sliding_window_median_filter.sv */
// Top level of the streaming zero-padded median filter.
//
// Pixels enter in raster order on in_valid_i/in_ready_o, one beat per pixel,
// opcode OP_FLUSH carrying a zero pixel. Results leave on out_valid_o/
// out_ready_i in raster order, lagging the input by h*W+h beats where
// h = window_size/2; after a frame the host sends h*W+h flush beats to drain.
// Configuration writes go on cfg_valid_i/cfg_index_i/cfg_data_i, always ready;
// in_ready_o stays low after a write while the derived sizes settle. Write
// them only while the block is idle. Throughput: one beat per cycle while
// the output is not stalled and no write settles, set by the line store port
// (one read and one write per column each cycle) and the column cell chain.
// Path: the result completed by an input beat reaches the output register
// through the column cells and three median stages after that beat is
// accepted; the line store read overlaps the accept.
// Reset clears counters and pipeline valid bits and loads default sizes
// (3, 640, 480); the line store needs no clearing, rows above the frame top
// are masked. A stalled receiver holds the output register; stages behind it
// keep filling until full, then in_ready_o drops.
`default_nettype none

module sliding_window_median_filter #(
  parameter int MAX_WINDOW = 7,
  parameter int MAX_WIDTH  = 1024
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       in_valid_i,
  output      logic                                       in_ready_o,
  input  wire swmf_pkg::in_beat_t                         in_data_i,
  output      logic                                       out_valid_o,
  input  wire logic                                       out_ready_i,
  output      swmf_pkg::out_beat_t                        out_data_o,
  input  wire logic                                       cfg_valid_i,
  output      logic                                       cfg_ready_o,
  input  wire logic [swmf_pkg::CFG_IDX_BITS-1:0]          cfg_index_i,
  input  wire logic [swmf_pkg::CFG_DATA_BITS-1:0]         cfg_data_i
);
  import swmf_pkg::*;

  localparam int HMAX    = (MAX_WINDOW - 1) / 2;
  localparam int WS      = 2 * HMAX + 1;
  localparam int LB_ROWS = (HMAX > 0) ? 2 * HMAX : 1;
  localparam int CB      = $clog2(MAX_WIDTH);
  localparam int WB      = $clog2(MAX_WIDTH + 1);
  localparam int PB      = $clog2(MAX_WIDTH * (MAX_HEIGHT + MAX_WINDOW));
  localparam int HB      = (HMAX > 0) ? $clog2(HMAX + 1) : 1;
  localparam int N       = WS * WS;
  localparam int RB      = (N > 1) ? $clog2(N) : 1;
  localparam int W_RST   = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
  localparam int H_RST   = (HMAX < 1) ? HMAX : 1;

  // configuration
  logic [WSIZE_BITS-1:0]  ws_q;
  logic [WIDTH_BITS-1:0]  iw_q;
  logic [HEIGHT_BITS-1:0] ih_q;
  logic [1:0]             cfg_wait_q;

  // derived sizes
  logic [WB-1:0]          w_d, w_q;
  logic [HEIGHT_BITS-1:0] hgt_d, hgt_q;
  logic [HB-1:0]          h_d, h_q;
  logic [PB-1:0]          total_q, lag_q;
  logic [RB-1:0]          tgt_q;
  logic [WSIZE_BITS-1:0]  hs;

  // input position
  logic [PB-1:0]          p_q, q;
  logic [CB-1:0]          col_q, qc_q;
  logic [HEIGHT_BITS-1:0] row_q;
  logic [WB-1:0]          col_inc, qc_inc;
  logic                   in_acc, past_lag, res, close;
  pixel_t                 val;

  // stage A
  logic                   va_q, resa_q;
  pixel_t                 vala_q;
  logic [CB-1:0]          cola_q, qca_q;
  logic [HEIGHT_BITS-1:0] rowa_q;
  tag_t                   taga_q;

  // stage B
  logic                   vb_q, resb_q;
  tag_t                   tagb_q;
  logic [WS-1:0]          colok_d, colok_q;

  logic                   adv_a, adv_b, rdy_b;
  pixel_t [LB_ROWS-1:0]   lb_rd, lb_wr;
  pixel_t [WS-1:0]        vcol;
  pixel_t [WS-1:0][WS-1:0] win;

  logic                   med_rdy, med_valid, out_load;
  pixel_t                 med_val;
  tag_t                   med_tag;
  out_beat_t              out_q;
  logic                   out_v_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q <= WSIZE_BITS'(3);
      iw_q <= WIDTH_BITS'(640);
      ih_q <= HEIGHT_BITS'(480);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WINDOW_SIZE:  ws_q <= cfg_data_i[WSIZE_BITS-1:0];
        CFG_IMAGE_WIDTH:  iw_q <= cfg_data_i[WIDTH_BITS-1:0];
        CFG_IMAGE_HEIGHT: ih_q <= cfg_data_i[HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input held off while the derived sizes settle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_wait_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_wait_q <= 2'd2;
    end else if (cfg_wait_q != '0) begin
      cfg_wait_q <= cfg_wait_q - 1'b1;
    end
  end

  assign hs = ws_q >> 1;

  always_comb begin
    if (iw_q == '0) begin
      w_d = WB'(1);
    end else if (int'(iw_q) > MAX_WIDTH) begin
      w_d = WB'(MAX_WIDTH);
    end else begin
      w_d = WB'(iw_q);
    end
    if (ih_q == '0) begin
      hgt_d = HEIGHT_BITS'(1);
    end else if (int'(ih_q) > MAX_HEIGHT) begin
      hgt_d = HEIGHT_BITS'(MAX_HEIGHT);
    end else begin
      hgt_d = ih_q;
    end
    h_d = (int'(hs) > HMAX) ? HB'(HMAX) : HB'(hs);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q     <= WB'(W_RST);
      hgt_q   <= HEIGHT_BITS'(480);
      h_q     <= HB'(H_RST);
      total_q <= PB'(W_RST * 480);
      lag_q   <= PB'(H_RST * W_RST + H_RST);
      tgt_q   <= RB'(((2 * H_RST + 1) * (2 * H_RST + 1)) / 2);
    end else begin
      w_q     <= w_d;
      hgt_q   <= hgt_d;
      h_q     <= h_d;
      total_q <= PB'(w_q * hgt_q);
      lag_q   <= PB'(h_q * w_q) + PB'(h_q);
      tgt_q   <= RB'(((({3'b0, h_q} << 1) + 1) * (({3'b0, h_q} << 1) + 1)) >> 1);
    end
  end

  assign in_acc   = in_valid_i && in_ready_o;
  assign past_lag = p_q >= lag_q;
  assign q        = p_q - lag_q;
  assign res      = past_lag && q < total_q;
  assign close    = past_lag && q >= total_q - 1'b1;
  assign val      = (in_data_i.opcode == OP_PIXEL && p_q < total_q) ?
                    in_data_i.pixel_value : '0;
  assign col_inc  = WB'(col_q) + 1'b1;
  assign qc_inc   = WB'(qc_q) + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q   <= '0;
      col_q <= '0;
      row_q <= '0;
      qc_q  <= '0;
    end else if (in_acc) begin
      if (close) begin
        p_q   <= '0;
        col_q <= '0;
        row_q <= '0;
        qc_q  <= '0;
      end else begin
        p_q <= p_q + 1'b1;
        if (col_inc >= w_q) begin
          col_q <= '0;
          row_q <= row_q + 1'b1;
        end else begin
          col_q <= CB'(col_inc);
        end
        if (past_lag) begin
          qc_q <= (qc_inc >= w_q) ? '0 : CB'(qc_inc);
        end
      end
    end
  end

  // handshake chain
  assign adv_b      = vb_q && (!resb_q || med_rdy);
  assign rdy_b      = !vb_q || adv_b;
  assign adv_a      = va_q && rdy_b;
  assign in_ready_o = (!va_q || adv_a) && cfg_wait_q == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (!va_q || adv_a) begin
        va_q <= in_acc;
      end
      if (rdy_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      vala_q            <= val;
      cola_q            <= col_q;
      rowa_q            <= row_q;
      resa_q            <= res;
      qca_q             <= qc_q;
      taga_q.row_last   <= WB'(qc_q) == w_q - 1'b1;
      taga_q.frame_last <= q == total_q - 1'b1;
    end
    if (adv_a) begin
      resb_q  <= resa_q;
      tagb_q  <= taga_q;
      colok_q <= colok_d;
    end
  end

  always_comb begin
    for (int j = 0; j < WS; j++) begin
      colok_d[j] = int'(qca_q) + j - HMAX >= 0 &&
                   int'(qca_q) + j - HMAX < int'(w_q);
    end
  end

  swmf_line_store #(
    .DEPTH (MAX_WIDTH),
    .ROWS  (LB_ROWS),
    .AW    (CB)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (col_q),
    .wr_en_i   (adv_a),
    .wr_addr_i (cola_q),
    .wr_data_i (lb_wr),
    .rd_data_o (lb_rd)
  );

  always_comb begin
    for (int k = 0; k < LB_ROWS; k++) begin
      lb_wr[k] = (k == 0) ? vala_q : lb_rd[(k > 0) ? k - 1 : 0];
    end
    vcol[0] = vala_q;
    for (int k = 1; k < WS; k++) begin
      vcol[k] = (k <= int'(rowa_q)) ? lb_rd[k-1] : '0;
    end
  end

  for (genvar c = 0; c < WS; c++) begin : g_cells
    swmf_col_cell #(
      .ROWS (WS)
    ) u_cell (
      .clk_i   (clk_i),
      .shift_i (adv_a),
      .col_i   ((c == 0) ? vcol : win[(c > 0) ? c - 1 : 0]),
      .col_o   (win[c])
    );
  end

  swmf_median #(
    .WS (WS),
    .HB (HB),
    .RB (RB)
  ) u_median (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vb_q && resb_q),
    .in_ready_o  (med_rdy),
    .win_i       (win),
    .colok_i     (colok_q),
    .h_i         (h_q),
    .tgt_i       (tgt_q),
    .tag_i       (tagb_q),
    .out_valid_o (med_valid),
    .out_ready_i (out_load),
    .median_o    (med_val),
    .tag_o       (med_tag)
  );

  assign out_load = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= med_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && med_valid) begin
      out_q.median_value <= med_val;
      out_q.row_last     <= med_tag.row_last;
      out_q.frame_last   <= med_tag.frame_last;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_frame_ends_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.row_last || !out_data_o.frame_last))
    else $error("frame end without row end");

  a_stage_a_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (va_q && !rdy_b) |=> (va_q && $stable(cola_q) && $stable(vala_q)))
    else $error("stage A lost a stalled beat");

  a_frame_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && close) |=> (p_q == '0 && qc_q == '0 && col_q == '0))
    else $error("position not cleared at frame close");
`endif

endmodule

`default_nettype wire

/* hdl/swmf_line_store.sv */
// Line store: previous image rows per column, one wide word per column.
`default_nettype none

module swmf_line_store #(
  parameter int DEPTH = 1024,
  parameter int ROWS  = 6,
  parameter int AW    = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          rd_en_i,
  input  wire logic [AW-1:0]                 rd_addr_i,
  input  wire logic                          wr_en_i,
  input  wire logic [AW-1:0]                 wr_addr_i,
  input  wire swmf_pkg::pixel_t [ROWS-1:0]   wr_data_i,
  output      swmf_pkg::pixel_t [ROWS-1:0]   rd_data_o
);
  import swmf_pkg::*;

  pixel_t [ROWS-1:0] mem [DEPTH];
  pixel_t [ROWS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // same-edge write to the read column is forwarded
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && wr_addr_i == rd_addr_i) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* hdl/swmf_col_cell.sv */
// Window column cell: holds one vertical slice and passes it to its neighbor.
`default_nettype none

module swmf_col_cell #(
  parameter int ROWS = 7
) (
  input  wire logic                        clk_i,
  input  wire logic                        shift_i,
  input  wire swmf_pkg::pixel_t [ROWS-1:0] col_i,
  output      swmf_pkg::pixel_t [ROWS-1:0] col_o
);
  import swmf_pkg::*;

  pixel_t [ROWS-1:0] col_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

`default_nettype wire

/* hdl/swmf_median.sv */
// Rank-based median select over the window cells, three pipeline stages.
`default_nettype none

module swmf_median #(
  parameter int WS = 7,
  parameter int HB = 2,
  parameter int RB = 6
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output      logic                                in_ready_o,
  input  wire swmf_pkg::pixel_t [WS-1:0][WS-1:0]   win_i,
  input  wire logic [WS-1:0]                       colok_i,
  input  wire logic [HB-1:0]                       h_i,
  input  wire logic [RB-1:0]                       tgt_i,
  input  wire swmf_pkg::tag_t                      tag_i,
  output      logic                                out_valid_o,
  input  wire logic                                out_ready_i,
  output      swmf_pkg::pixel_t                    median_o,
  output      swmf_pkg::tag_t                      tag_o
);
  import swmf_pkg::*;

  localparam int HM = (WS - 1) / 2;
  localparam int N  = WS * WS;

  pixel_t [N-1:0]   cv_d, cv_q, dv_q, ev_q;
  logic   [N-1:0]   ca_d, ca_q, da_q, ea_q;
  logic   [N-1:0]   lt_d [N];
  logic   [N-1:0]   lt_q [N];
  logic   [RB-1:0]  rank_q [N];
  logic   [RB-1:0]  ctgt_q, dtgt_q, etgt_q;
  tag_t             ctag_q, dtag_q, etag_q;
  logic             vc_q, vd_q, ve_q;
  logic             rdy_c, rdy_d, rdy_e;
  pixel_t           med;

  assign rdy_e      = !ve_q || out_ready_i;
  assign rdy_d      = !vd_q || rdy_e;
  assign rdy_c      = !vc_q || rdy_d;
  assign in_ready_o = rdy_c;

  always_comb begin
    for (int i = 0; i < WS; i++) begin
      for (int j = 0; j < WS; j++) begin
        ca_d[i*WS+j] = 1'b0;
        cv_d[i*WS+j] = '0;
        for (int hv = 0; hv <= HM; hv++) begin
          if (h_i == HB'(hv) && i - HM <= hv && HM - i <= hv &&
              j - HM <= hv && HM - j <= hv) begin
            ca_d[i*WS+j] = 1'b1;
            cv_d[i*WS+j] = colok_i[j] ? win_i[hv-(j-HM)][hv-(i-HM)] : '0;
          end
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        lt_d[i][j] = ca_q[j] && j != i &&
                     (cv_q[j] < cv_q[i] || (cv_q[j] == cv_q[i] && j < i));
      end
    end
  end

  always_comb begin
    med = '0;
    for (int i = 0; i < N; i++) begin
      if (ea_q[i] && rank_q[i] == etgt_q) begin
        med = med | ev_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      if (rdy_c) begin
        vc_q <= in_valid_i;
      end
      if (rdy_d) begin
        vd_q <= vc_q;
      end
      if (rdy_e) begin
        ve_q <= vd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c && in_valid_i) begin
      cv_q   <= cv_d;
      ca_q   <= ca_d;
      ctgt_q <= tgt_i;
      ctag_q <= tag_i;
    end
    if (rdy_d && vc_q) begin
      lt_q   <= lt_d;
      dv_q   <= cv_q;
      da_q   <= ca_q;
      dtgt_q <= ctgt_q;
      dtag_q <= ctag_q;
    end
    if (rdy_e && vd_q) begin
      for (int i = 0; i < N; i++) begin
        rank_q[i] <= RB'($countones(lt_q[i]));
      end
      ev_q   <= dv_q;
      ea_q   <= da_q;
      etgt_q <= dtgt_q;
      etag_q <= dtag_q;
    end
  end

  assign out_valid_o = ve_q;
  assign median_o    = med;
  assign tag_o       = etag_q;

endmodule

`default_nettype wire
